// ----- sv/pbrle_pkg.sv -----
// Package for the PackBits row encoder: item types, packet descriptor and
// the command and status groups between controller and datapath. No dependencies.
`default_nettype none

package pbrle_pkg;

  localparam int MAX_PACKET_DEF = 128;
  localparam int CNT_W = 8;
  localparam logic [8:0] REP_BASE = 9'd257;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        end_of_packet;
    logic        row_done;
  } out_item_t;

  typedef struct packed {
    logic             lit;
    logic [7:0]       hdr;
    logic [7:0]       rbyte;
    logic [CNT_W-1:0] len;
    logic             fin;
  } pkt_desc_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic q_nonempty;
    logic last_byte;
    logic word_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/pbrle_ctrl.sv -----
// Controller of the PackBits row encoder: sequences item load, packet start
// and byte steps. Depends on pbrle_pkg.
`default_nettype none

module pbrle_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  raw_valid,
  input  wire pbrle_pkg::dp_status_t status,
  output pbrle_pkg::ctl_cmd_t        cmd,
  output logic                       busy
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_EMIT} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (raw_valid) begin
          cmd.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.q_nonempty) begin
          cmd.pop = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!status.word_done || status.out_free) begin
          cmd.step = 1'b1;
          if (status.last_byte) begin
            if (status.q_nonempty) begin
              cmd.pop = 1'b1;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/pbrle_datapath.sv -----
// Datapath of the PackBits row encoder: run state, literal store, packet
// queue, byte packer and output register. Depends on pbrle_pkg.
`default_nettype none

module pbrle_datapath #(
  parameter int MAX_PACKET = pbrle_pkg::MAX_PACKET_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pbrle_pkg::in_item_t  raw_item,
  input  wire pbrle_pkg::ctl_cmd_t  cmd,
  output pbrle_pkg::dp_status_t     status,
  output logic                      code_valid,
  input  wire logic                 code_stall,
  output pbrle_pkg::out_item_t      code_item
);

  localparam int ADDR_W = $clog2(MAX_PACKET);
  localparam int CW = pbrle_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_PACKET);

  function automatic pbrle_pkg::pkt_desc_t rep_desc(input logic [CW-1:0] run,
                                                    input logic [7:0] value);
    pbrle_pkg::pkt_desc_t d;
    d.lit   = 1'b0;
    d.hdr   = 8'(pbrle_pkg::REP_BASE - {1'b0, run});
    d.rbyte = value;
    d.len   = CW'(1);
    d.fin   = 1'b0;
    return d;
  endfunction

  function automatic pbrle_pkg::pkt_desc_t lit_desc(input logic [CW-1:0] n);
    pbrle_pkg::pkt_desc_t d;
    d.lit   = 1'b1;
    d.hdr   = 8'(n - CW'(1));
    d.rbyte = '0;
    d.len   = n;
    d.fin   = 1'b0;
    return d;
  endfunction

  logic [7:0] store [MAX_PACKET];
  logic [7:0] rd_data;

  logic [CW-1:0] pl;
  logic [CW-1:0] rl;
  logic [7:0]    prev;
  logic          rm;

  logic [CW-1:0] pl_next;
  logic [CW-1:0] rl_next;
  logic [7:0]    prev_next;
  logic          rm_next;
  logic [CW-1:0] pl_mid;
  logic          wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic          eq;
  pbrle_pkg::pkt_desc_t desc_a;
  pbrle_pkg::pkt_desc_t desc_b;
  logic          a_valid;
  logic          b_valid;

  pbrle_pkg::pkt_desc_t q0;
  pbrle_pkg::pkt_desc_t q1;
  logic [1:0]    qn;

  pbrle_pkg::pkt_desc_t cur;
  logic          head;
  logic [CW-1:0] rem;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;

  logic [63:0]   word;
  logic [2:0]    wcnt;
  logic [63:0]   merged;
  logic [7:0]    byte_val;
  logic          last_byte;
  logic          word_done;

  always_comb begin
    eq        = (raw_item.data_byte == prev);
    pl_next   = pl;
    rl_next   = rl;
    prev_next = prev;
    rm_next   = rm;
    wr_en     = 1'b1;
    wr_addr   = pl[ADDR_W-1:0];
    desc_a    = '0;
    a_valid   = 1'b0;
    if (pl == '0) begin
      prev_next = raw_item.data_byte;
      pl_next   = CW'(1);
      rl_next   = CW'(1);
    end else if (pl == CW'(1)) begin
      pl_next = CW'(2);
      rm_next = eq;
      if (eq) begin
        rl_next = rl + CW'(1);
      end else begin
        rl_next   = CW'(1);
        prev_next = raw_item.data_byte;
      end
    end else if (rm) begin
      if (eq) begin
        pl_next = pl + CW'(1);
        rl_next = rl + CW'(1);
        wr_en   = 1'b0;
      end else begin
        desc_a    = rep_desc(rl, prev);
        a_valid   = 1'b1;
        wr_addr   = '0;
        prev_next = raw_item.data_byte;
        pl_next   = CW'(1);
        rl_next   = CW'(1);
        rm_next   = 1'b0;
      end
    end else begin
      pl_next = pl + CW'(1);
      if (eq) begin
        rl_next = rl + CW'(1);
        if (rl >= CW'(2)) begin
          desc_a    = lit_desc(pl - CW'(2));
          a_valid   = (pl > CW'(2));
          rm_next   = 1'b1;
          prev_next = raw_item.data_byte;
          pl_next   = CW'(3);
          rl_next   = CW'(3);
        end
      end else begin
        rl_next   = CW'(1);
        prev_next = raw_item.data_byte;
      end
    end

    pl_mid  = pl_next;
    b_valid = (pl_mid >= MAX_LEN) || (raw_item.end_of_row && (pl_mid != '0));
    desc_b  = rm_next ? rep_desc(rl_next, prev_next) : lit_desc(pl_mid);
    if (pl_mid >= MAX_LEN) begin
      pl_next = '0;
    end
    desc_b.fin = raw_item.end_of_row;
    desc_a.fin = raw_item.end_of_row && !b_valid;
    if (raw_item.end_of_row) begin
      pl_next = '0;
      rl_next = '0;
      rm_next = 1'b0;
    end
  end

  always_comb begin
    byte_val  = head ? cur.hdr : (cur.lit ? rd_data : cur.rbyte);
    last_byte = !head && (rem == CW'(1));
    word_done = last_byte || (wcnt == 3'd7);
    merged    = word;
    merged[{wcnt, 3'b000} +: 8] = byte_val;
    if (cmd.pop) begin
      ptr_next = '0;
    end else if (cmd.step && !head) begin
      ptr_next = ptr + ADDR_W'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign status.q_nonempty = (qn != 2'd0);
  assign status.last_byte  = last_byte;
  assign status.word_done  = word_done;
  assign status.out_free   = !code_valid || !code_stall;

  always_ff @(posedge clk) begin
    rd_data <= store[ptr_next];
    if (cmd.load && wr_en) begin
      store[wr_addr] <= raw_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl         <= '0;
      rl         <= '0;
      prev       <= '0;
      rm         <= 1'b0;
      qn         <= 2'd0;
      head       <= 1'b1;
      ptr        <= '0;
      wcnt       <= 3'd0;
      word       <= '0;
      code_valid <= 1'b0;
    end else begin
      ptr <= ptr_next;
      if (cmd.load) begin
        pl   <= pl_next;
        rl   <= rl_next;
        prev <= prev_next;
        rm   <= rm_next;
        q0   <= a_valid ? desc_a : desc_b;
        q1   <= desc_b;
        qn   <= {1'b0, a_valid} + {1'b0, b_valid};
      end
      if (cmd.step) begin
        if (head) begin
          head <= 1'b0;
        end else if (!cmd.pop) begin
          rem <= rem - CW'(1);
        end
        if (word_done) begin
          code_item.out_word      <= merged;
          code_item.byte_count    <= {1'b0, wcnt} + 4'd1;
          code_item.end_of_packet <= last_byte;
          code_item.row_done      <= last_byte && cur.fin;
          word <= '0;
          wcnt <= 3'd0;
        end else begin
          word <= merged;
          wcnt <= wcnt + 3'd1;
        end
      end
      if (cmd.pop) begin
        cur  <= q0;
        q0   <= q1;
        qn   <= qn - 2'd1;
        head <= 1'b1;
        rem  <= q0.len;
      end
      if (cmd.step && word_done) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/packbits_rle_encoder_unit.sv -----
// Top level of the PackBits row encoder: joins controller and datapath.
// Depends on pbrle_pkg, pbrle_ctrl and pbrle_datapath.
//
//   Channel  Direction  Carries                      Handshake
//   raw      in         one row byte, end of row     raw_valid / raw_stall
//   code     out        packed word of packet bytes  code_valid / code_stall
//
// A byte that closes no packet passes from S_IDLE through S_START back to S_IDLE.
// A byte that closes packets then steps out each encoded byte (headers included) in S_EMIT;
// the literal store is read one byte per cycle while code_stall does not hold the packer.
// A word waiting on code_stall holds the packer only when the next word is complete.
// Reset clears run state and queue; the literal store is not cleared.
// raw_stall is high from an accepted byte until its last encoded byte is packed.
`default_nettype none

module packbits_rle_encoder_unit #(
  parameter int MAX_PACKET = pbrle_pkg::MAX_PACKET_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                raw_valid,
  output logic                     raw_stall,
  input  wire pbrle_pkg::in_item_t raw_item,
  output logic                     code_valid,
  input  wire logic                code_stall,
  output pbrle_pkg::out_item_t     code_item
);

  pbrle_pkg::ctl_cmd_t   cmd;
  pbrle_pkg::dp_status_t status;

  pbrle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .status    (status),
    .cmd       (cmd),
    .busy      (raw_stall)
  );

  pbrle_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .raw_item   (raw_item),
    .cmd        (cmd),
    .status     (status),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

endmodule

`default_nettype wire

// ----- sv/pbrle_checker.sv -----
// Port-level checks for the PackBits row encoder, bound to the top level.
// Depends on pbrle_pkg and packbits_rle_encoder_unit.
`default_nettype none

module pbrle_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 raw_valid,
  input wire logic                 raw_stall,
  input wire logic                 code_valid,
  input wire logic                 code_stall,
  input wire pbrle_pkg::out_item_t code_item
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (code_item.byte_count != 4'd0 && code_item.byte_count <= 4'd8))
    else $error("word byte count out of range");

  a_short_word_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code_item.byte_count != 4'd8) |-> code_item.end_of_packet)
    else $error("partial word that does not end a packet");

  a_row_done_on_packet_end: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code_item.row_done) |-> code_item.end_of_packet)
    else $error("row end flagged inside a packet");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (raw_valid && !raw_stall) |=> raw_stall)
    else $error("byte taken while the previous one is in work");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code_stall) |=> (code_valid && $stable(code_item)))
    else $error("stalled word changed");

endmodule

bind packbits_rle_encoder_unit pbrle_checker u_pbrle_checker (.*);

`default_nettype wire
